>>> sv/hbe_pkg.sv
// Shared types and constants of the hierarchical basis evaluator.
package hbe_pkg;

	localparam logic [47:0] ONE_Q30 = 48'h0000_4000_0000;
	localparam logic [47:0] RES_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] RES_MIN = 48'h8000_0000_0000;

	localparam logic [1:0] ACT_VAL1  = 2'd0;
	localparam logic [1:0] ACT_GRAD1 = 2'd1;
	localparam logic [1:0] ACT_VAL2  = 2'd2;
	localparam logic [1:0] ACT_GRAD2 = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] x;
		logic signed [31:0] node_point;
		logic signed [31:0] left_point;
		logic signed [31:0] right_point;
		logic               is_root;
	} item_t;

	typedef struct packed {
		logic signed [47:0] result;
		logic               saturated;
	} res_t;

	// what the arithmetic does with an item after the piece is chosen
	typedef enum logic [3:0] {
		K_ZERO,
		K_ONE,
		K_LIN_VAL,
		K_LIN_GRAD,
		K_C1L,
		K_C1R,
		K_G1,
		K_T2L,
		K_T2R,
		K_G2L,
		K_G2R
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  neg;
	} ctx_t;

	typedef struct packed {
		kind_t       kind;
		logic        neg;
		logic        satpre;
		logic [33:0] p3;
	} ctx2_t;

endpackage

>>> sv/hbe_div.sv
// Pipelined restoring divider: one quotient bit per stage, floor((num << SH) / den).
module hbe_div #(
	parameter int QW = 31,
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int SH = 30,
	parameter int CW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [CW-1:0] in_ctx,
	output logic          out_valid,
	output logic [QW-1:0] out_quo,
	output logic [DW-1:0] out_den,
	output logic [CW-1:0] out_ctx
);

	localparam int TW = NW + SH;

	logic [TW-1:0] dividend;
	logic [DW-1:0] rem0;
	logic [QW-1:0] low0;

	logic          vld_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [CW-1:0] ctx_s [QW];

	assign dividend = {in_num, {SH{1'b0}}};
	// upper dividend bits start as the partial remainder, the rest shift in
	assign rem0 = DW'(dividend >> QW);
	assign low0 = dividend[QW-1:0];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] r_in;
		logic [QW-1:0] l_in;
		logic [DW-1:0] d_in;
		logic [CW-1:0] c_in;
		logic          v_in;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign r_in = rem0;
			assign l_in = low0;
			assign d_in = in_den;
			assign c_in = in_ctx;
			assign v_in = in_valid;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign l_in = low_s[k-1];
			assign d_in = den_s[k-1];
			assign c_in = ctx_s[k-1];
			assign v_in = vld_s[k-1];
		end

		assign trial = {r_in, l_in[QW-1]};
		assign ge    = trial >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, d_in}) : DW'(trial);
				low_s[k] <= {l_in[QW-2:0], ge};
				den_s[k] <= d_in;
				ctx_s[k] <= c_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign out_quo   = low_s[QW-1];
	assign out_den   = den_s[QW-1];
	assign out_ctx   = ctx_s[QW-1];

endmodule

>>> sv/hierarchical_basis_eval.sv
// Top level: hierarchical hat / cubic Hermite basis evaluation pipeline.
//
//   port group                  dir  handshake           payload
//   item_valid/item_stall/item  in   valid, stall        hbe_pkg::item_t
//   res_valid/res_stall/res     out  valid, stall        hbe_pkg::res_t
//   cfg_valid/cfg_ready/cfg_data in  valid, ready        interp_mode (1 bit)
//
// One item per cycle while the skid register is empty. Stages: decode, 31 stages
// of the piece fraction divider, four operand and multiply stages, 48 stages of the
// gradient divider, output register. A skid register behind the output takes
// one item while res is stalled; the pipeline freezes while it is full.
// Reset clears valid bits and interp_mode (linear).
module hierarchical_basis_eval (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  hbe_pkg::item_t item,
	output logic          res_valid,
	input  logic          res_stall,
	output hbe_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);

	logic mode_q;
	logic en;

	// decode
	hbe_pkg::ctx_t dec_ctx;
	logic [31:0]   dec_num;
	logic [31:0]   dec_den;
	logic [31:0]   dxl, dnl, dxn, drn, drx;
	logic          x_lt_n, x_gt_n, x_eq_n, x_ge_l, x_gt_l, x_le_r, x_lt_r, r_eq_n;

	logic          vld_s1;
	hbe_pkg::ctx_t ctx_s1;
	logic [31:0]   num_s1, den_s1;

	logic          d1_vld;
	logic [30:0]   d1_quo;
	logic [31:0]   d1_den;
	hbe_pkg::ctx_t d1_ctx;

	// operand prep
	logic [30:0]   t, u;
	logic [33:0]   t3;
	logic [30:0]   pre_ma;
	logic [32:0]   pre_mb;
	logic [31:0]   pre_mc;
	logic [32:0]   pre_md;
	hbe_pkg::ctx_t pre_ctx;

	logic          vld_s2;
	hbe_pkg::ctx_t ctx_s2;
	logic [30:0]   ma_s2;
	logic [32:0]   mb_s2;
	logic [31:0]   mc_s2;
	logic [32:0]   md_s2;
	logic [31:0]   den_s2;

	logic          vld_s3;
	hbe_pkg::ctx_t ctx_s3;
	logic [32:0]   p1_s3;
	logic [31:0]   mc_s3;
	logic [32:0]   md_s3;
	logic [31:0]   den_s3;
	logic [63:0]   prod1;

	logic          vld_s4;
	hbe_pkg::ctx_t ctx_s4;
	logic [32:0]   p2_s4;
	logic [32:0]   md_s4;
	logic [31:0]   den_s4;
	logic [64:0]   prod2;

	logic          vld_s5;
	hbe_pkg::ctx_t ctx_s5;
	logic [33:0]   p3_s5;
	logic [31:0]   den_s5;
	logic [65:0]   prod3;

	hbe_pkg::ctx2_t d2_in_ctx;
	logic           d2_vld;
	logic [47:0]    d2_quo;
	logic [31:0]    d2_den;
	hbe_pkg::ctx2_t d2_ctx;

	hbe_pkg::res_t fin;
	logic [47:0]   p3_ext;

	logic          out_valid_q, skid_valid_q;
	hbe_pkg::res_t out_q, skid_q;
	logic          res_fire, push;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign en         = !skid_valid_q;
	assign item_stall = skid_valid_q;

	// piece selection
	assign dxl = item.x - item.left_point;
	assign dnl = item.node_point - item.left_point;
	assign dxn = item.x - item.node_point;
	assign drn = item.right_point - item.node_point;
	assign drx = item.right_point - item.x;

	assign x_lt_n = item.x < item.node_point;
	assign x_gt_n = item.x > item.node_point;
	assign x_eq_n = item.x == item.node_point;
	assign x_ge_l = item.x >= item.left_point;
	assign x_gt_l = item.x > item.left_point;
	assign x_le_r = item.x <= item.right_point;
	assign x_lt_r = item.x < item.right_point;
	assign r_eq_n = item.right_point == item.node_point;

	always_comb begin
		dec_ctx.kind = hbe_pkg::K_ZERO;
		dec_ctx.neg  = 1'b0;
		dec_num      = dxl;
		dec_den      = dnl;
		if (item.is_root) begin
			if (item.action == hbe_pkg::ACT_VAL1 && x_ge_l && x_le_r) begin
				dec_ctx.kind = hbe_pkg::K_ONE;
			end
		end else begin
			unique case (item.action)
				hbe_pkg::ACT_VAL1: begin
					if (!mode_q) begin
						if (x_lt_n && x_ge_l) begin
							dec_ctx.kind = hbe_pkg::K_LIN_VAL;
						end else if (!x_lt_n && x_le_r) begin
							dec_ctx.kind = r_eq_n ? hbe_pkg::K_ONE : hbe_pkg::K_LIN_VAL;
							dec_num      = drx;
							dec_den      = drn;
						end
					end else begin
						if (x_lt_n && x_ge_l) begin
							dec_ctx.kind = hbe_pkg::K_C1L;
						end else if (!x_lt_n && x_lt_r) begin
							dec_ctx.kind = hbe_pkg::K_C1R;
							dec_num      = dxn;
							dec_den      = drn;
						end else if (x_eq_n && r_eq_n) begin
							dec_ctx.kind = hbe_pkg::K_ONE;
						end
					end
				end
				hbe_pkg::ACT_GRAD1: begin
					if (x_lt_n && x_gt_l) begin
						dec_ctx.kind = mode_q ? hbe_pkg::K_G1 : hbe_pkg::K_LIN_GRAD;
					end else if (x_gt_n && x_lt_r) begin
						dec_ctx.kind = mode_q ? hbe_pkg::K_G1 : hbe_pkg::K_LIN_GRAD;
						dec_ctx.neg  = 1'b1;
						dec_num      = dxn;
						dec_den      = drn;
					end
				end
				hbe_pkg::ACT_VAL2: begin
					if (mode_q) begin
						if (!x_gt_n && x_gt_l) begin
							dec_ctx.kind = hbe_pkg::K_T2L;
						end else if (!x_lt_n && x_lt_r) begin
							dec_ctx.kind = hbe_pkg::K_T2R;
							dec_num      = dxn;
							dec_den      = drn;
						end
					end
				end
				hbe_pkg::ACT_GRAD2: begin
					if (mode_q) begin
						if (x_lt_n && x_gt_l) begin
							dec_ctx.kind = hbe_pkg::K_G2L;
						end else if (x_gt_n && x_lt_r) begin
							dec_ctx.kind = hbe_pkg::K_G2R;
							dec_num      = dxn;
							dec_den      = drn;
						end else if (x_eq_n) begin
							dec_ctx.kind = hbe_pkg::K_ONE;
						end
					end
				end
				default: begin
					dec_ctx.kind = hbe_pkg::K_ZERO;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= dec_ctx;
			num_s1 <= dec_num;
			den_s1 <= dec_den;
		end
	end

	// t = floor(num * 2^30 / den), at most 1.0
	hbe_div #(
		.QW (31),
		.NW (32),
		.DW (32),
		.SH (30),
		.CW ($bits(hbe_pkg::ctx_t))
	) u_div_frac (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_ctx    (ctx_s1),
		.out_valid (d1_vld),
		.out_quo   (d1_quo),
		.out_den   (d1_den),
		.out_ctx   (d1_ctx)
	);

	// multiplier operands: result magnitude is ((ma * mb >> 30) * mc >> 30) * md >> 30
	assign t  = d1_quo;
	assign u  = 31'(hbe_pkg::ONE_Q30) - t;
	assign t3 = 34'(t) + 34'({t, 1'b0});

	always_comb begin
		pre_ctx = d1_ctx;
		pre_ma  = 31'(hbe_pkg::ONE_Q30);
		pre_mb  = 33'(hbe_pkg::ONE_Q30);
		pre_mc  = 32'(hbe_pkg::ONE_Q30);
		pre_md  = 33'(hbe_pkg::ONE_Q30);
		case (d1_ctx.kind)
			hbe_pkg::K_LIN_VAL: begin
				pre_ma = t;
			end
			hbe_pkg::K_C1L: begin
				pre_ma = t;
				pre_mb = 33'(t);
				pre_mc = 32'(34'(3) * 34'(hbe_pkg::ONE_Q30) - 34'({t, 1'b0}));
			end
			hbe_pkg::K_C1R: begin
				pre_ma = u;
				pre_mb = 33'(u);
				pre_mc = 32'(34'(hbe_pkg::ONE_Q30) + 34'({t, 1'b0}));
			end
			hbe_pkg::K_G1: begin
				pre_ma = t;
				pre_mb = 33'(u);
				pre_md = 33'(34'(6) * 34'(hbe_pkg::ONE_Q30));
			end
			hbe_pkg::K_T2L: begin
				pre_ma = t;
				pre_mb = 33'(t);
				pre_mc = 32'(u);
				pre_md = 33'(d1_den);
			end
			hbe_pkg::K_T2R: begin
				pre_ma = u;
				pre_mb = 33'(u);
				pre_mc = 32'(t);
				pre_md = 33'(d1_den);
			end
			hbe_pkg::K_G2L: begin
				pre_ma = t;
				if (t3 < (34'(hbe_pkg::ONE_Q30) << 1)) begin
					pre_mb      = 33'((34'(hbe_pkg::ONE_Q30) << 1) - t3);
					pre_ctx.neg = 1'b1;
				end else begin
					pre_mb = 33'(t3 - (34'(hbe_pkg::ONE_Q30) << 1));
				end
			end
			hbe_pkg::K_G2R: begin
				pre_ma = t;
				pre_mb = 33'((34'(hbe_pkg::ONE_Q30) << 2) - t3);
			end
			default: begin
				pre_ma = 31'(hbe_pkg::ONE_Q30);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s2 <= d1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign prod1 = 64'(ma_s2) * 64'(mb_s2);
	assign prod2 = 65'(p1_s3) * 65'(mc_s3);
	assign prod3 = 66'(p2_s4) * 66'(md_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2 <= pre_ctx;
			ma_s2  <= pre_ma;
			mb_s2  <= pre_mb;
			mc_s2  <= pre_mc;
			md_s2  <= pre_md;
			den_s2 <= d1_den;

			ctx_s3 <= ctx_s2;
			p1_s3  <= prod1[62:30];
			mc_s3  <= mc_s2;
			md_s3  <= md_s2;
			den_s3 <= den_s2;

			ctx_s4 <= ctx_s3;
			p2_s4  <= prod2[62:30];
			md_s4  <= md_s3;
			den_s4 <= den_s3;

			ctx_s5 <= ctx_s4;
			p3_s5  <= prod3[63:30];
			den_s5 <= den_s4;
		end
	end

	// a quotient of 2^48 or more saturates whatever the sign
	always_comb begin
		d2_in_ctx.kind   = ctx_s5.kind;
		d2_in_ctx.neg    = ctx_s5.neg;
		d2_in_ctx.p3     = p3_s5;
		d2_in_ctx.satpre = 50'(p3_s5) >= {den_s5, 18'd0};
	end

	// gradient = floor(m * 2^30 / den)
	hbe_div #(
		.QW (48),
		.NW (34),
		.DW (32),
		.SH (30),
		.CW ($bits(hbe_pkg::ctx2_t))
	) u_div_grad (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.in_num    (p3_s5),
		.in_den    (den_s5),
		.in_ctx    (d2_in_ctx),
		.out_valid (d2_vld),
		.out_quo   (d2_quo),
		.out_den   (d2_den),
		.out_ctx   (d2_ctx)
	);

	// sign, offset and clip
	assign p3_ext = 48'(d2_ctx.p3);

	always_comb begin
		fin.result    = '0;
		fin.saturated = 1'b0;
		case (d2_ctx.kind)
			hbe_pkg::K_ONE: begin
				fin.result = hbe_pkg::ONE_Q30;
			end
			hbe_pkg::K_LIN_VAL, hbe_pkg::K_C1L, hbe_pkg::K_C1R, hbe_pkg::K_T2R: begin
				fin.result = p3_ext;
			end
			hbe_pkg::K_T2L: begin
				fin.result = -p3_ext;
			end
			hbe_pkg::K_G2L: begin
				fin.result = d2_ctx.neg ? -p3_ext : p3_ext;
			end
			hbe_pkg::K_G2R: begin
				fin.result = hbe_pkg::ONE_Q30 - p3_ext;
			end
			hbe_pkg::K_LIN_GRAD, hbe_pkg::K_G1: begin
				if (d2_ctx.satpre) begin
					fin.saturated = 1'b1;
					fin.result    = d2_ctx.neg ? hbe_pkg::RES_MIN : hbe_pkg::RES_MAX;
				end else if (!d2_ctx.neg) begin
					if (d2_quo[47]) begin
						fin.saturated = 1'b1;
						fin.result    = hbe_pkg::RES_MAX;
					end else begin
						fin.result = d2_quo;
					end
				end else begin
					// exactly 2^47 still fits as the most negative value
					if (d2_quo[47] && |d2_quo[46:0]) begin
						fin.saturated = 1'b1;
						fin.result    = hbe_pkg::RES_MIN;
					end else begin
						fin.result = -d2_quo;
					end
				end
			end
			default: begin
				fin.result = '0;
			end
		endcase
	end

	// output register with one skid entry
	assign res_fire = out_valid_q && !res_stall;
	assign push     = en && d2_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (res_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || res_fire) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (res_fire) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || res_fire) begin
			if (push) begin
				out_q <= fin;
			end
		end else if (push) begin
			skid_q <= fin;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

>>> test/tb.sv
// Self-checking testbench for the hierarchical basis evaluator.
module tb;

	localparam int    DRAIN_CYCLES = 120;
	localparam int    CYCLE_LIMIT  = 300000;
	localparam longint RES_HI = (64'sd1 <<< 47) - 1;
	localparam longint RES_LO = -(64'sd1 <<< 47);
	localparam longint Q30 = 64'sd1 <<< 30;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   item_valid = 1'b0;
	logic   item_stall;
	hbe_pkg::item_t  item = '0;
	logic   res_valid;
	logic   res_stall = 1'b0;
	hbe_pkg::res_t   res;
	logic   cfg_valid = 1'b0;
	logic   cfg_ready;
	logic   cfg_data = 1'b0;

	hbe_pkg::item_t  item_fifo[$];
	hbe_pkg::res_t   expected_res[$];
	logic   cubic_mode = 1'b0;
	int     cyc = 0;
	int     errors = 0;

	hierarchical_basis_eval dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// fraction of the piece, floor(num * 2^30 / den)
	function automatic longint frac30(longint num, longint den);
		longint unsigned q;
		q = (longint'(num) << 30) / den;
		return longint'(q);
	endfunction

	// Q30 product truncated toward zero
	function automatic longint mul30(longint a, longint b);
		longint unsigned ma, mb;
		longint p;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = longint'((ma * mb) >> 30);
		return ((a < 0) != (b < 0)) ? -p : p;
	endfunction

	function automatic longint slope30(longint m, longint den, bit neg);
		longint q;
		q = longint'((longint'(m) << 30) / den);
		return neg ? -q : q;
	endfunction

	function automatic longint basis_raw(hbe_pkg::item_t it, logic cubic);
		longint x, n, l, r, t, u;
		x = it.x;
		n = it.node_point;
		l = it.left_point;
		r = it.right_point;
		if (it.is_root)
			return (it.action == hbe_pkg::ACT_VAL1 && x >= l && x <= r) ? Q30 : 0;
		case (it.action)
			hbe_pkg::ACT_VAL1: begin
				if (!cubic) begin
					if (x < n && x >= l) return frac30(x - l, n - l);
					if (x >= n && x <= r) return (r == n) ? Q30 : frac30(r - x, r - n);
					return 0;
				end
				if (x < n && x >= l) begin
					t = frac30(x - l, n - l);
					return mul30(mul30(t, t), 3 * Q30 - 2 * t);
				end
				if (x >= n && x < r) begin
					t = frac30(x - n, r - n);
					u = Q30 - t;
					return mul30(mul30(u, u), Q30 + 2 * t);
				end
				return (x == n && x == r) ? Q30 : 0;
			end
			hbe_pkg::ACT_GRAD1: begin
				if (!cubic) begin
					if (x < n && x > l) return slope30(Q30, n - l, 1'b0);
					if (x > n && x < r) return slope30(Q30, r - n, 1'b1);
					return 0;
				end
				if (x < n && x > l) begin
					t = frac30(x - l, n - l);
					return slope30(6 * mul30(t, Q30 - t), n - l, 1'b0);
				end
				if (x > n && x < r) begin
					t = frac30(x - n, r - n);
					return slope30(6 * mul30(t, Q30 - t), r - n, 1'b1);
				end
				return 0;
			end
			hbe_pkg::ACT_VAL2: begin
				if (!cubic) return 0;
				if (x <= n && x > l) begin
					t = frac30(x - l, n - l);
					return -mul30(n - l, mul30(mul30(t, t), Q30 - t));
				end
				if (x >= n && x < r) begin
					t = frac30(x - n, r - n);
					u = Q30 - t;
					return mul30(r - n, mul30(mul30(u, u), t));
				end
				return 0;
			end
			default: begin
				if (!cubic) return 0;
				if (x < n && x > l) begin
					t = frac30(x - l, n - l);
					return mul30(t, 3 * t - 2 * Q30);
				end
				if (x > n && x < r) begin
					t = frac30(x - n, r - n);
					return mul30(t, 3 * t - 4 * Q30) + Q30;
				end
				return (x == n) ? Q30 : 0;
			end
		endcase
	endfunction

	function automatic hbe_pkg::res_t eval_basis(hbe_pkg::item_t it, logic cubic);
		longint v;
		hbe_pkg::res_t o;
		v = basis_raw(it, cubic);
		o.saturated = 1'b0;
		if (v > RES_HI) begin
			v = RES_HI;
			o.saturated = 1'b1;
		end else if (v < RES_LO) begin
			v = RES_LO;
			o.saturated = 1'b1;
		end
		o.result = v[47:0];
		return o;
	endfunction

	function automatic bit calm_window();
		return cyc >= 100 && cyc < 400;
	endfunction

	// driver: hold a stalled item, advance on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_res.push_back(eval_basis(item, cubic_mode));
			if (!item_valid || !item_stall) begin
				if (item_fifo.size() > 0 && (calm_window() || $urandom_range(99) >= 28)) begin
					item <= item_fifo.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		hbe_pkg::res_t want;
		cyc <= cyc + 1;
		if (arst_n) begin
			res_stall <= !calm_window() && $urandom_range(99) < 28;
			if (res_valid && !res_stall) begin
				if (expected_res.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected item: result=%h sat=%b", res.result, res.saturated);
				end else begin
					want = expected_res.pop_front();
					if (res.result !== want.result || res.saturated !== want.saturated) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: exp result=%h sat=%b, got result=%h sat=%b",
								want.result, want.saturated, res.result, res.saturated);
					end
				end
			end
		end
		if (cyc >= CYCLE_LIMIT) begin
			$display("hierarchical_basis_eval regression: fail");
			$finish;
		end
	end

	task automatic add_item(logic [1:0] act, longint x, longint n, longint l, longint r,
			logic root);
		hbe_pkg::item_t it;
		it.action = act;
		it.x = x[31:0];
		it.node_point = n[31:0];
		it.left_point = l[31:0];
		it.right_point = r[31:0];
		it.is_root = root;
		item_fifo.push_back(it);
	endtask

	task automatic add_directed();
		longint lo, hi;
		lo = -(64'sd1 <<< 31);
		hi = (64'sd1 <<< 31) - 1;
		add_item(hbe_pkg::ACT_VAL1, 0, 0, -Q30, Q30, 1'b1);
		add_item(hbe_pkg::ACT_VAL1, Q30 + 1, 0, -Q30, Q30, 1'b1);
		add_item(hbe_pkg::ACT_VAL1, -Q30, 0, -Q30, Q30, 1'b1);
		add_item(hbe_pkg::ACT_GRAD1, 0, 0, -Q30, Q30, 1'b1);
		add_item(hbe_pkg::ACT_GRAD2, 0, 0, -Q30, Q30, 1'b1);
		// x at the node; the first two with node equal to right neighbour
		add_item(hbe_pkg::ACT_VAL1, 5, 5, 0, 5, 1'b0);
		add_item(hbe_pkg::ACT_GRAD2, 5, 5, 0, 5, 1'b0);
		add_item(hbe_pkg::ACT_VAL2, 5, 5, 0, 9, 1'b0);
		// empty piece
		add_item(hbe_pkg::ACT_VAL1, 3, 0, 7, -4, 1'b0);
		add_item(hbe_pkg::ACT_GRAD1, 3, 0, 7, -4, 1'b0);
		// pieces of length two: gradients overflow
		add_item(hbe_pkg::ACT_GRAD1, 1, 2, 0, 3, 1'b0);
		add_item(hbe_pkg::ACT_GRAD1, 2, 1, 0, 3, 1'b0);
		add_item(hbe_pkg::ACT_GRAD1, 1, 2, 0, 4, 1'b0);
		// full-range points
		add_item(hbe_pkg::ACT_VAL1, 0, 0, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_VAL2, lo + 1, hi, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_VAL2, hi - 1, lo, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_GRAD2, -12345, 0, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_GRAD2, 12345, 0, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_GRAD1, hi, hi, lo, hi, 1'b0);
		add_item(hbe_pkg::ACT_VAL1, lo, lo, lo, hi, 1'b1);
	endtask

	function automatic longint rand_span();
		int k;
		k = $urandom_range(31);
		return longint'({$urandom, $urandom}) & ((64'sd1 <<< k) - 1);
	endfunction

	task automatic add_random(int count);
		longint l, n, r, x, total;
		logic [1:0] act;
		repeat (count) begin
			act = 2'($urandom_range(3));
			if ($urandom_range(9) < 8) begin
				l = $signed($urandom);
				n = l + ($urandom_range(7) == 0 ? 0 : rand_span());
				r = n + ($urandom_range(7) == 0 ? 0 : rand_span());
				total = r - l;
				case ($urandom_range(5))
					0: x = l;
					1: x = n;
					2: x = r;
					3: x = l - 1 - $urandom_range(3);
					default: x = l + longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF)
						% (total + 1);
				endcase
				add_item(act, x, n, l, r, $urandom_range(9) == 0);
			end else begin
				add_item(act, $signed($urandom), $signed($urandom), $signed($urandom),
					$signed($urandom), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic wait_drained();
		wait (item_fifo.size() == 0 && !item_valid && expected_res.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cubic_mode = m;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_directed();
		add_random(250);
		wait_drained();
		write_mode(1'b1);
		add_directed();
		add_random(350);
		wait_drained();
		write_mode(1'b0);
		add_random(250);
		wait_drained();
		write_mode(1'b1);
		add_random(350);
		wait_drained();
		if (errors == 0)
			$display("hierarchical_basis_eval regression: pass");
		else
			$display("hierarchical_basis_eval regression: fail");
		$finish;
	end
endmodule
